[design/bmscm_pkg.sv]
// Shared types and constants for the battery-monitor CAN block.
`default_nettype none
package bmscm_pkg;
  localparam logic [28:0] ID_MIN_CELL  = 29'h301;
  localparam logic [28:0] ID_TIMEOUT   = 29'h305;
  localparam logic [28:0] ID_POLL_306  = 29'h306;
  localparam logic [28:0] ID_PROTECT   = 29'h307;
  localparam logic [28:0] ID_POLL_308  = 29'h308;
  localparam logic [28:0] ID_QUERY     = 29'h380;
  localparam logic [28:0] ID_CHG_REQ   = 29'h1806E5F4;
  localparam logic [28:0] ID_CHARGER   = 29'h18FF50E5;
  localparam logic [15:0] PID_LOW_RED  = 16'h0008;
  localparam logic [15:0] PID_UV       = 16'h0004;
  localparam logic [16:0] UNCONSTRAINED_DA = 17'd99980;
  localparam logic [15:0] CHG_BLOCK_MASK = 16'hC81A;
  localparam logic [15:0] DIS_BLOCK_MASK = 16'h2005;
  localparam logic [8:0]  CELL_OFFSET  = 9'd200;

  typedef enum logic [1:0] {
    QP_FIRST  = 2'd0,
    QP_SECOND = 2'd1,
    QP_DONE   = 2'd2,
    QP_SPARE  = 2'd3
  } qphase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPDATE, ST_DIV, ST_EMIT, ST_HOLD
  } state_t;

  typedef enum logic [2:0] {
    SL_FRAME, SL_P301, SL_P305, SL_P306, SL_P307, SL_P308, SL_QUERY, SL_CHARGER
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic   update;     // apply the request to state
    logic   div_start;
    logic   load_out;   // capture a result into the output register
    slot_t  slot;
    logic   out_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic is_tick;
    logic send_query;
    logic send_charger;
  } dp_sts_t;
endpackage
`default_nettype wire

[design/bmscm_div.sv]
// Restoring divider for the reduction level, one quotient bit per cycle.
`default_nettype none
module bmscm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [18:0] dividend,
  input  wire logic [9:0]  divisor,
  output logic             done,
  output logic [18:0]      quotient
);
  logic [18:0] q_r, q_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [10:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[9:0], q_r[18]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 5'd19;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt   = {q_r[17:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[17:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = busy_r && (cnt_r == 5'd1);
  assign quotient = q_nxt;
endmodule
`default_nettype wire

[design/bmscm_datapath.sv]
// State registers, frame decode, tick update, status and result formatting.
`default_nettype none
module bmscm_datapath #(
  parameter int STOP_DEBOUNCE_TICKS  = 50,
  parameter int QUERY_PERIOD_TICKS   = 5,
  parameter int CHARGER_PERIOD_TICKS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  input  wire logic              in_fire,
  input  wire logic [127:0]      in_tdata,
  input  wire bmscm_pkg::dp_cmd_t cmd,
  output bmscm_pkg::dp_sts_t     sts,
  output logic [144:0]           res_data
);
  localparam logic [5:0] STOP_MAX = 6'(STOP_DEBOUNCE_TICKS);
  localparam logic [2:0] QPER     = 3'(QUERY_PERIOD_TICKS);
  localparam logic [3:0] CPER     = 4'(CHARGER_PERIOD_TICKS);

  // request capture
  logic         act_r;
  logic [28:0]  fid_r;
  logic [63:0]  fdat_r;
  logic         cmode_r;
  logic [15:0]  vbus_r;
  logic [15:0]  ichg_r;

  logic [7:0]  tsec_r;
  logic [11:0] tcount_r, tcount_nxt;
  logic [8:0]  mincell_r, mincell_nxt;
  logic [15:0] prot_r, prot_nxt;
  logic [7:0]  redb_r, redb_nxt;
  logic [15:0] reqcur_r, reqcur_nxt;
  logic        stopreq_r, stopreq_nxt;
  logic        link_r, link_nxt;
  bmscm_pkg::qphase_t qph_r, qph_nxt;
  logic [8:0]  lowth_r, lowth_nxt, uvth_r, uvth_nxt;
  logic [2:0]  qtick_r, qtick_nxt;
  logic [3:0]  ctick_r, ctick_nxt;
  logic [5:0]  deb_r, deb_nxt;
  logic        cperm_r, cperm_nxt;
  logic        sendq_r, sendq_nxt, sendc_r, sendc_nxt;
  logic        qfirst_r, qfirst_nxt;
  logic [10:0] level_r;

  logic [15:0] pid;
  logic        chg_ok_pre, valid_now, chg_ok_now, dis_ok_now;
  logic [16:0] maxchg;
  logic [2:0]  qt_inc;
  logic [3:0]  ct_inc;
  logic [15:0] cur;
  logic [9:0]  band;
  logic [18:0] dividend, quot;
  logic        div_done;
  logic        use_div;
  logic [10:0] lvl_fixed, lvl_div, lvl;

  assign pid        = {fdat_r[7:0], fdat_r[15:8]};
  // charge check sees the timeout after this tick's decrement
  assign chg_ok_pre = (tcount_r > 12'd1) &&
                      ((prot_r & bmscm_pkg::CHG_BLOCK_MASK) == 16'd0);
  assign qt_inc     = qtick_r + 3'd1;
  assign ct_inc     = ctick_r + 4'd1;

  always_comb begin
    tcount_nxt = tcount_r;  mincell_nxt = mincell_r; prot_nxt = prot_r;
    redb_nxt = redb_r;      reqcur_nxt = reqcur_r;   stopreq_nxt = stopreq_r;
    link_nxt = link_r;      qph_nxt = qph_r;         lowth_nxt = lowth_r;
    uvth_nxt = uvth_r;      qtick_nxt = qtick_r;     ctick_nxt = ctick_r;
    deb_nxt = deb_r;        cperm_nxt = cperm_r;
    sendq_nxt = sendq_r;    sendc_nxt = sendc_r;     qfirst_nxt = qfirst_r;
    if (cmd.update) begin
      sendq_nxt = 1'b0;
      sendc_nxt = 1'b0;
      if (act_r) begin
        if (tcount_r != 12'd0) tcount_nxt = tcount_r - 12'd1;
        if (!chg_ok_pre || stopreq_r) begin
          if (deb_r < STOP_MAX) deb_nxt = deb_r + 6'd1;
          if (deb_nxt >= STOP_MAX) cperm_nxt = 1'b0;
        end else begin
          deb_nxt   = '0;
          cperm_nxt = 1'b1;
        end
        if (qph_r == bmscm_pkg::QP_FIRST || qph_r == bmscm_pkg::QP_SECOND) begin
          qtick_nxt = qt_inc;
          if (qt_inc >= QPER) begin
            qtick_nxt  = '0;
            sendq_nxt  = 1'b1;
            qfirst_nxt = (qph_r == bmscm_pkg::QP_FIRST);
          end
        end
        if (cmode_r) begin
          ctick_nxt = ct_inc;
          if (ct_inc >= CPER) begin
            ctick_nxt = '0;
            sendc_nxt = 1'b1;
          end
        end else begin
          ctick_nxt   = '0;
          stopreq_nxt = 1'b0;
          deb_nxt     = '0;
          cperm_nxt   = 1'b1;
        end
      end else begin
        case (fid_r)
          bmscm_pkg::ID_MIN_CELL: mincell_nxt = {1'b0, fdat_r[7:0]} + bmscm_pkg::CELL_OFFSET;
          bmscm_pkg::ID_TIMEOUT:  tcount_nxt = {4'd0, tsec_r} * 12'd10;
          bmscm_pkg::ID_PROTECT: begin
            prot_nxt = fdat_r[15:0];
            redb_nxt = fdat_r[39:32];
          end
          bmscm_pkg::ID_CHG_REQ: begin
            reqcur_nxt  = {fdat_r[23:16], fdat_r[31:24]};
            stopreq_nxt = fdat_r[32];
            link_nxt    = 1'b1;
          end
          bmscm_pkg::ID_QUERY: begin
            if (pid == bmscm_pkg::PID_LOW_RED && qph_r == bmscm_pkg::QP_FIRST) begin
              lowth_nxt = {1'b0, fdat_r[55:48]} + bmscm_pkg::CELL_OFFSET;
              qph_nxt   = bmscm_pkg::QP_SECOND;
            end else if (pid == bmscm_pkg::PID_UV && qph_r == bmscm_pkg::QP_SECOND) begin
              uvth_nxt = {1'b0, fdat_r[55:48]} + bmscm_pkg::CELL_OFFSET;
              qph_nxt  = bmscm_pkg::QP_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsec_r <= 8'd5;    tcount_r <= '0;  mincell_r <= bmscm_pkg::CELL_OFFSET;
      prot_r <= '0;      redb_r <= '0;    reqcur_r <= '0;  stopreq_r <= 1'b0;
      link_r <= 1'b0;    qph_r <= bmscm_pkg::QP_FIRST;
      lowth_r <= '0;     uvth_r <= '0;    qtick_r <= '0;   ctick_r <= '0;
      deb_r <= '0;       cperm_r <= 1'b1; sendq_r <= 1'b0; sendc_r <= 1'b0;
      qfirst_r <= 1'b0;
    end else begin
      if (cfg_wr_en) tsec_r <= cfg_wr_data;
      tcount_r <= tcount_nxt;  mincell_r <= mincell_nxt; prot_r <= prot_nxt;
      redb_r <= redb_nxt;      reqcur_r <= reqcur_nxt;   stopreq_r <= stopreq_nxt;
      link_r <= link_nxt;      qph_r <= qph_nxt;         lowth_r <= lowth_nxt;
      uvth_r <= uvth_nxt;      qtick_r <= qtick_nxt;     ctick_r <= ctick_nxt;
      deb_r <= deb_nxt;        cperm_r <= cperm_nxt;
      sendq_r <= sendq_nxt;    sendc_r <= sendc_nxt;     qfirst_r <= qfirst_nxt;
    end
    if (in_fire) begin
      act_r   <= in_tdata[0];
      fid_r   <= in_tdata[29:1];
      fdat_r  <= in_tdata[93:30];
      cmode_r <= in_tdata[94];
      vbus_r  <= in_tdata[110:95];
      ichg_r  <= in_tdata[126:111];
    end
  end

  // reduction level, launched after the state update
  assign valid_now = tcount_r != 12'd0;
  assign band      = {1'b0, lowth_r} - {1'b0, uvth_r};
  assign dividend  = (mincell_r > uvth_r) ? {(mincell_r - uvth_r), 10'd0} : 19'd0;
  assign use_div   = redb_r[0] && lowth_r != 9'd0 && uvth_r != 9'd0 && lowth_r > uvth_r;

  bmscm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dividend), .divisor(band), .done(div_done), .quotient(quot)
  );

  always_comb begin
    lvl_fixed = 11'd1024;
    if (redb_r[0] && (lowth_r == 9'd0 || uvth_r == 9'd0)) lvl_fixed = 11'd512;
    if (redb_r[1] && lvl_fixed > 11'd768) lvl_fixed = 11'd768;
    if (redb_r[2] || redb_r[5]) lvl_fixed = 11'd512;
    lvl_div = (quot > 19'd1024) ? 11'd1024 : quot[10:0];
    lvl = lvl_fixed;
    if (use_div && lvl_div < lvl) lvl = lvl_div;
    if (!valid_now || redb_r == 8'd0) lvl = 11'd1024;
  end

  always_ff @(posedge clk) begin
    if (div_done) level_r <= lvl;
  end

  assign chg_ok_now = valid_now && ((prot_r & bmscm_pkg::CHG_BLOCK_MASK) == 16'd0);
  assign dis_ok_now = valid_now && ((prot_r & bmscm_pkg::DIS_BLOCK_MASK) == 16'd0);
  assign maxchg = !cperm_r ? 17'd0 :
                  (!link_r || reqcur_r == 16'd0) ? bmscm_pkg::UNCONSTRAINED_DA :
                  {1'b0, reqcur_r};
  assign cur = (ichg_r == 16'd0 || ichg_r[15]) ? 16'd0 : ichg_r;

  assign sts.div_done     = div_done;
  assign sts.is_tick      = act_r;
  assign sts.send_query   = sendq_r;
  assign sts.send_charger = sendc_r;

  always_comb begin
    logic        txv;
    logic [28:0] txid;
    logic [3:0]  txlen;
    logic [63:0] txd;
    txv = 1'b1; txlen = 4'd0; txd = '0; txid = '0;
    case (cmd.slot)
      bmscm_pkg::SL_FRAME: txv = 1'b0;
      bmscm_pkg::SL_P301:  txid = bmscm_pkg::ID_MIN_CELL;
      bmscm_pkg::SL_P305:  txid = bmscm_pkg::ID_TIMEOUT;
      bmscm_pkg::SL_P306:  txid = bmscm_pkg::ID_POLL_306;
      bmscm_pkg::SL_P307:  txid = bmscm_pkg::ID_PROTECT;
      bmscm_pkg::SL_P308:  txid = bmscm_pkg::ID_POLL_308;
      bmscm_pkg::SL_QUERY: begin
        txid  = bmscm_pkg::ID_QUERY;
        txlen = 4'd3;
        txd   = qfirst_r ? 64'h010800 : 64'h010400;
      end
      bmscm_pkg::SL_CHARGER: begin
        txid  = bmscm_pkg::ID_CHARGER;
        txlen = 4'd8;
        txd   = {32'd0, cur[7:0], cur[15:8], vbus_r[7:0], vbus_r[15:8]};
      end
      default: txv = 1'b0;
    endcase
    res_data = {(valid_now ? mincell_r : 9'd0), deb_r, level_r, maxchg,
                dis_ok_now, chg_ok_now, valid_now, cmd.out_last,
                txd, txlen, txid, txv};
  end
endmodule
`default_nettype wire

[design/bmscm_ctrl.sv]
// Sequencer: update, divide, then walk the result slots through the output register.
`default_nettype none
module bmscm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_free,
  input  wire bmscm_pkg::dp_sts_t sts,
  output bmscm_pkg::dp_cmd_t     cmd,
  output logic                   in_ready
);
  bmscm_pkg::state_t state_r, state_nxt;
  bmscm_pkg::slot_t  slot_r, slot_nxt;
  logic              is_last;

  always_comb begin
    is_last = 1'b1;
    case (slot_r)
      bmscm_pkg::SL_FRAME:   is_last = 1'b1;
      bmscm_pkg::SL_P308:    is_last = !sts.send_query && !sts.send_charger;
      bmscm_pkg::SL_QUERY:   is_last = !sts.send_charger;
      bmscm_pkg::SL_CHARGER: is_last = 1'b1;
      default:               is_last = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    case (state_r)
      bmscm_pkg::ST_IDLE:   if (in_fire) state_nxt = bmscm_pkg::ST_UPDATE;
      bmscm_pkg::ST_UPDATE: state_nxt = bmscm_pkg::ST_HOLD;
      bmscm_pkg::ST_HOLD: begin
        state_nxt = bmscm_pkg::ST_DIV;
      end
      bmscm_pkg::ST_DIV: if (sts.div_done) begin
        state_nxt = bmscm_pkg::ST_EMIT;
        slot_nxt  = sts.is_tick ? bmscm_pkg::SL_P301 : bmscm_pkg::SL_FRAME;
      end
      bmscm_pkg::ST_EMIT: if (out_free) begin
        if (is_last) state_nxt = bmscm_pkg::ST_IDLE;
        else if (slot_r == bmscm_pkg::SL_P308)
          slot_nxt = sts.send_query ? bmscm_pkg::SL_QUERY : bmscm_pkg::SL_CHARGER;
        else if (slot_r == bmscm_pkg::SL_QUERY) slot_nxt = bmscm_pkg::SL_CHARGER;
        else slot_nxt = bmscm_pkg::slot_t'(slot_r + 3'd1);
      end
      default: state_nxt = bmscm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.update    = (state_r == bmscm_pkg::ST_UPDATE);
    cmd.div_start = (state_r == bmscm_pkg::ST_HOLD);
    cmd.load_out  = (state_r == bmscm_pkg::ST_EMIT) && out_free;
    cmd.slot      = slot_r;
    cmd.out_last  = is_last;
    in_ready      = (state_r == bmscm_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmscm_pkg::ST_IDLE;
      slot_r  <= bmscm_pkg::SL_FRAME;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end
endmodule
`default_nettype wire

[design/bms_can_monitor_unit.sv]
// Top level of the battery-monitor CAN block.
`default_nettype none
// A request is a received CAN frame or a 100 ms tick. Frames yield one status
// result; ticks yield five poll frames plus an optional query frame and an
// optional charger frame. One request at a time: it is accepted, then passes
// the update state, the divider launch state and restoring division for the
// reduction level; results then leave one per cycle while the output is free.
// The output register holds a result until it is taken; the next result is
// loaded in the cycle the current one leaves.
module bms_can_monitor_unit #(
  parameter int STOP_DEBOUNCE_TICKS  = 50,
  parameter int QUERY_PERIOD_TICKS   = 5,
  parameter int CHARGER_PERIOD_TICKS = 10
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [7:0]   cfg_wr_data,  // timeout_seconds
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // action, frame_id, frame_data, charge_mode, bus_voltage_dv, charge_current_dv
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tx_valid, tx_id, tx_length, tx_data, data_valid, charge_allowed,
  // discharge_allowed, max_charge_current_da, reduction_level, stop_count,
  // min_cell_voltage_cv
  output logic [143:0]      out_tdata,
  output logic              out_tlast
);
  bmscm_pkg::dp_cmd_t cmd;
  bmscm_pkg::dp_sts_t sts;
  logic [144:0] res;
  logic in_fire, out_free;
  logic vld_r;
  logic [144:0] dat_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !vld_r || out_tready;

  bmscm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .in_ready(in_tready)
  );

  bmscm_datapath #(
    .STOP_DEBOUNCE_TICKS(STOP_DEBOUNCE_TICKS),
    .QUERY_PERIOD_TICKS(QUERY_PERIOD_TICKS),
    .CHARGER_PERIOD_TICKS(CHARGER_PERIOD_TICKS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_fire(in_fire), .in_tdata(in_tdata), .cmd(cmd), .sts(sts), .res_data(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (cmd.load_out) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
    if (cmd.load_out) dat_r <= res;
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = dat_r[98];
  assign out_tdata  = {dat_r[144:99], dat_r[97:0]};
endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the battery-monitor CAN block (bms_can_monitor_unit).
module testbench;
  localparam int STOP_DEBOUNCE_TICKS  = 50;
  localparam int QUERY_PERIOD_TICKS   = 5;
  localparam int CHARGER_PERIOD_TICKS = 10;

  typedef struct {
    bit        tx_valid;
    bit [28:0] tx_id;
    bit [3:0]  tx_len;
    bit [63:0] tx_data;
    bit        last;
    bit        data_valid;
    bit        chg_ok;
    bit        dis_ok;
    bit [16:0] max_chg;
    bit [10:0] red_level;
    bit [5:0]  stop_cnt;
    bit [8:0]  min_cell;
  } can_result_t;

  class can_monitor_board;
    can_result_t pending[$];
    int          errors;
    bit [7:0]    window_s;
    bit [11:0]   timeout_cnt;
    bit [8:0]    min_cell_code;
    bit [15:0]   prot_bits;
    bit [7:0]    red_bits;
    bit [15:0]   req_current;
    bit          stop_req;
    bit          link_up;
    bmscm_pkg::qphase_t phase;
    bit [8:0]    low_thr;
    bit [8:0]    uv_thr;
    bit [2:0]    query_cnt;
    bit [3:0]    charger_cnt;
    bit [5:0]    debounce;
    bit          permitted;

    function new();
      errors = 0;
      window_s = 8'd5;
      timeout_cnt = '0;
      min_cell_code = bmscm_pkg::CELL_OFFSET;
      prot_bits = '0;
      red_bits = '0;
      req_current = '0;
      stop_req = 0;
      link_up = 0;
      phase = bmscm_pkg::QP_FIRST;
      low_thr = '0;
      uv_thr = '0;
      query_cnt = '0;
      charger_cnt = '0;
      debounce = '0;
      permitted = 1;
    endfunction

    function bit fresh();
      return timeout_cnt != 0;
    endfunction

    function bit charge_ok();
      return fresh() && ((prot_bits & bmscm_pkg::CHG_BLOCK_MASK) == 0);
    endfunction

    function int unsigned level_q10();
      int unsigned lvl;
      int unsigned band;
      int unsigned q;
      lvl = 1024;
      if (!fresh() || red_bits == 0) return 1024;
      if (red_bits[0]) begin
        if (low_thr != 0 && uv_thr != 0) begin
          if (low_thr > uv_thr) begin
            band = low_thr - uv_thr;
            q = (min_cell_code > uv_thr) ? ((min_cell_code - uv_thr) * 1024) / band : 0;
            if (q < lvl) lvl = q;
          end
        end else if (lvl > 512) begin
          lvl = 512;
        end
      end
      if (red_bits[1] && lvl > 768) lvl = 768;
      if ((red_bits[2] || red_bits[5]) && lvl > 512) lvl = 512;
      return lvl;
    endfunction

    function can_result_t tx_frame(bit v, bit [28:0] id, bit [3:0] len, bit [63:0] d);
      can_result_t r;
      r = '{default: 0};
      r.tx_valid = v;
      r.tx_id = id;
      r.tx_len = len;
      r.tx_data = d;
      return r;
    endfunction

    // Apply one accepted request and queue the results it should produce.
    function void note_request(bit [127:0] req);
      can_result_t batch[$];
      bit [28:0]   id;
      bit [63:0]   d;
      bit [15:0]   volt;
      bit [15:0]   cur;
      bit [15:0]   pid;
      bit [28:0]   polls[5];
      id = req[29:1];
      d = req[93:30];
      volt = req[110:95];
      cur = req[126:111];
      polls = '{bmscm_pkg::ID_MIN_CELL, bmscm_pkg::ID_TIMEOUT, bmscm_pkg::ID_POLL_306,
                bmscm_pkg::ID_PROTECT, bmscm_pkg::ID_POLL_308};
      if (!req[0]) begin
        if (id == bmscm_pkg::ID_MIN_CELL) begin
          min_cell_code = d[7:0] + bmscm_pkg::CELL_OFFSET;
        end else if (id == bmscm_pkg::ID_TIMEOUT) begin
          timeout_cnt = window_s * 10;
        end else if (id == bmscm_pkg::ID_PROTECT) begin
          prot_bits = d[15:0];
          red_bits = d[39:32];
        end else if (id == bmscm_pkg::ID_CHG_REQ) begin
          req_current = {d[23:16], d[31:24]};
          stop_req = d[32];
          link_up = 1;
        end else if (id == bmscm_pkg::ID_QUERY) begin
          pid = {d[7:0], d[15:8]};
          if (pid == bmscm_pkg::PID_LOW_RED && phase == bmscm_pkg::QP_FIRST) begin
            low_thr = d[55:48] + bmscm_pkg::CELL_OFFSET;
            phase = bmscm_pkg::QP_SECOND;
          end else if (pid == bmscm_pkg::PID_UV && phase == bmscm_pkg::QP_SECOND) begin
            uv_thr = d[55:48] + bmscm_pkg::CELL_OFFSET;
            phase = bmscm_pkg::QP_DONE;
          end
        end
        batch.push_back(tx_frame(0, '0, '0, '0));
      end else begin
        if (timeout_cnt > 0) timeout_cnt--;
        if (!charge_ok() || stop_req) begin
          if (debounce < STOP_DEBOUNCE_TICKS) debounce++;
          if (debounce >= STOP_DEBOUNCE_TICKS) permitted = 0;
        end else begin
          debounce = 0;
          permitted = 1;
        end
        foreach (polls[i]) batch.push_back(tx_frame(1, polls[i], '0, '0));
        if (phase == bmscm_pkg::QP_FIRST || phase == bmscm_pkg::QP_SECOND) begin
          query_cnt++;
          if (query_cnt >= QUERY_PERIOD_TICKS) begin
            query_cnt = 0;
            batch.push_back(tx_frame(1, bmscm_pkg::ID_QUERY, 4'd3,
                                     (phase == bmscm_pkg::QP_FIRST) ? 64'h010800 :
                                                                      64'h010400));
          end
        end
        if (req[94]) begin
          charger_cnt++;
          if (charger_cnt >= CHARGER_PERIOD_TICKS) begin
            charger_cnt = 0;
            if (cur[15]) cur = '0;
            batch.push_back(tx_frame(1, bmscm_pkg::ID_CHARGER, 4'd8,
                                     {32'd0, cur[7:0], cur[15:8], volt[7:0], volt[15:8]}));
          end
        end else begin
          charger_cnt = 0;
          stop_req = 0;
          debounce = 0;
          permitted = 1;
        end
      end
      foreach (batch[k]) begin
        batch[k].last = (k == batch.size() - 1);
        batch[k].data_valid = fresh();
        batch[k].chg_ok = charge_ok();
        batch[k].dis_ok = fresh() && ((prot_bits & bmscm_pkg::DIS_BLOCK_MASK) == 0);
        batch[k].max_chg = !permitted ? 17'd0 :
                           (!link_up || req_current == 0) ? bmscm_pkg::UNCONSTRAINED_DA :
                           17'(req_current);
        batch[k].red_level = 11'(level_q10());
        batch[k].stop_cnt = debounce;
        batch[k].min_cell = fresh() ? min_cell_code : 9'd0;
        pending.push_back(batch[k]);
      end
    endfunction

    task report(string what, bit [63:0] got, bit [63:0] want);
      errors++;
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    endtask

    task check_result(bit [143:0] t, bit tl);
      can_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", t[63:0], 0);
        return;
      end
      e = pending.pop_front();
      if (t[0] != e.tx_valid) report("tx_valid", t[0], e.tx_valid);
      if (t[29:1] != e.tx_id) report("tx_id", t[29:1], e.tx_id);
      if (t[33:30] != e.tx_len) report("tx_length", t[33:30], e.tx_len);
      if (t[97:34] != e.tx_data) report("tx_data", t[97:34], e.tx_data);
      if (tl != e.last) report("last", tl, e.last);
      if (t[98] != e.data_valid) report("data_valid", t[98], e.data_valid);
      if (t[99] != e.chg_ok) report("charge_allowed", t[99], e.chg_ok);
      if (t[100] != e.dis_ok) report("discharge_allowed", t[100], e.dis_ok);
      if (t[117:101] != e.max_chg) report("max_charge_current", t[117:101], e.max_chg);
      if (t[128:118] != e.red_level) report("reduction_level", t[128:118], e.red_level);
      if (t[134:129] != e.stop_cnt) report("stop_count", t[134:129], e.stop_cnt);
      if (t[143:135] != e.min_cell) report("min_cell_voltage", t[143:135], e.min_cell);
    endtask
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_wr_en = 0;
  logic [7:0]   cfg_wr_data = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [143:0] out_tdata;
  logic         out_tlast;

  can_monitor_board board = new();
  bit      no_idle = 0;
  bit      rx_hold = 0;
  longint  cycles = 0;

  bms_can_monitor_unit #(
    .STOP_DEBOUNCE_TICKS(STOP_DEBOUNCE_TICKS),
    .QUERY_PERIOD_TICKS(QUERY_PERIOD_TICKS),
    .CHARGER_PERIOD_TICKS(CHARGER_PERIOD_TICKS)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast);
    out_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 13);
  end

  function automatic bit [127:0] pack_request(bit act, bit [28:0] id, bit [63:0] d,
                                              bit cm, bit [15:0] volt, bit [15:0] cur);
    return {1'b0, cur, volt, cm, d, id, act};
  endfunction

  function automatic bit [127:0] tick(bit cm);
    return pack_request(1, $urandom, {$urandom, $urandom}, cm, $urandom, $urandom);
  endfunction

  function automatic bit [127:0] frame(bit [28:0] id, bit [63:0] d);
    return pack_request(0, id, d, $urandom, $urandom, $urandom);
  endfunction

  // Mostly well-formed traffic with random payloads; some unknown ids.
  function automatic bit [127:0] random_request();
    bit [63:0] d;
    int        pick;
    d = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 40) return tick($urandom_range(99) < 85);
    if (pick < 48) return frame(bmscm_pkg::ID_MIN_CELL, d);
    if (pick < 58) return frame(bmscm_pkg::ID_TIMEOUT, d);
    if (pick < 68) begin
      if ($urandom_range(1)) d[15:0] = '0;
      return frame(bmscm_pkg::ID_PROTECT, d);
    end
    if (pick < 78) return frame(bmscm_pkg::ID_CHG_REQ, d);
    if (pick < 90) begin
      if ($urandom_range(1))
        d[15:0] = {$urandom_range(1) ? bmscm_pkg::PID_UV[7:0] : bmscm_pkg::PID_LOW_RED[7:0],
                   8'h00};
      return frame(bmscm_pkg::ID_QUERY, d);
    end
    return frame(29'($urandom), d);
  endfunction

  task automatic send(bit [127:0] req);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(req);
  endtask

  task automatic drain_and_configure(bit [7:0] secs);
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= secs;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.window_s = secs;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    drain_and_configure(8'd5);

    // directed: thresholds missing, every frame kind, broken and good query replies
    send(frame(bmscm_pkg::ID_TIMEOUT, 64'h0));
    send(frame(bmscm_pkg::ID_PROTECT, 64'h0000_0001_0000_0000));
    send(tick(1));
    send(frame(bmscm_pkg::ID_MIN_CELL, 64'hFF));
    send(frame(bmscm_pkg::ID_MIN_CELL, 64'h00));
    send(frame(bmscm_pkg::ID_CHG_REQ, 64'h0000_0001_3412_0000));
    send(frame(bmscm_pkg::ID_QUERY, 64'h0032_0000_0000_0400));
    send(frame(bmscm_pkg::ID_QUERY, 64'h0032_0000_0000_0900));
    send(frame(29'h1FFF_FFFF, '1));
    send(frame(bmscm_pkg::ID_PROTECT, 64'h0000_0024_FFFF));
    send(tick(0));
    send(tick(1));
    send(tick(1));
    send(pack_request(1, '0, '0, 1, 16'hFFFF, 16'h8000));
    send(pack_request(1, '0, '0, 1, 16'h1234, 16'h7FFF));
    send(frame(bmscm_pkg::ID_QUERY, 64'h0064_0000_0000_0800));
    send(frame(bmscm_pkg::ID_QUERY, 64'h0000_0000_0000_0800));
    send(tick(1));
    send(frame(bmscm_pkg::ID_QUERY, 64'h0010_0000_0000_0400));
    send(frame(bmscm_pkg::ID_PROTECT, 64'h0000_0003_0000));
    send(frame(bmscm_pkg::ID_MIN_CELL, 64'h40));
    send(frame(bmscm_pkg::ID_CHG_REQ, 64'h0));
    send(tick(1));

    no_idle = 1;
    repeat (40) send(random_request());
    no_idle = 0;
    fork
      begin
        rx_hold <= 1;
        repeat (400) @(posedge clk);
        rx_hold <= 0;
      end
    join_none
    repeat (70) send(random_request());

    drain_and_configure(8'd255);
    repeat (80) send(random_request());

    // no refresh window: charge stop debounce runs up to saturation
    drain_and_configure(8'd0);
    repeat (60) send(tick(1));
    repeat (10) send(random_request());

    drain_and_configure(8'd1);
    repeat (70) send(random_request());

    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
